// ----- sv/assert_macros.svh -----
// Assertion macros shared by the stream decoder RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition holds whenever a guard holds.
`define ASSERT_WHEN(lbl, clk, rst_n, guard, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (guard) |-> (cond)) \
        else $error(msg);
`endif

// ----- sv/tga_pkg.sv -----
// Types, codes and the pixel unpack function for the TGA stream decoder.
// No dependencies.
`default_nettype none
package tga_pkg;
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_MAP    = 3'd2,
        PH_PIXELS = 3'd3,
        PH_IDLE   = 3'd4
    } phase_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_DEPTH = 2'd2;
    localparam logic [1:0] ERR_MAP   = 2'd3;

    localparam logic [7:0] TYPE_MAPPED   = 8'd1;
    localparam logic [7:0] TYPE_TRUE     = 8'd2;
    localparam logic [7:0] TYPE_GREY     = 8'd3;
    localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
    localparam logic [7:0] TYPE_RLE_GREY = 8'd11;

    localparam logic [4:0] HDR_LAST = 5'd17;

    // Packed RGBA: red in bits 7:0 up to alpha in bits 31:24.
    function automatic logic [31:0] unpack(input logic [31:0] p, input logic [2:0] n);
        logic [7:0] p0, p1, p2, p3, r, g, b, a;
        p0 = p[7:0];
        p1 = p[15:8];
        p2 = p[23:16];
        p3 = p[31:24];
        case (n)
            3'd1: begin r = p0; g = p0; b = p0; a = 8'hff; end
            3'd2:
            begin
                r = {p1[6:2], 3'b000};
                g = {p1[1:0], p0[7:5], 3'b000};
                b = {p0[4:0], 3'b000};
                a = p1 & 8'h80;
            end
            3'd3: begin r = p2; g = p1; b = p0; a = 8'hff; end
            3'd0: begin r = 8'd0; g = 8'd0; b = 8'd0; a = 8'd0; end
            default: begin r = p2; g = p1; b = p0; a = p3; end
        endcase
        return {a, b, g, r};
    endfunction
endpackage
`default_nettype wire

// ----- sv/tga_stream_decoder_top.sv -----
// A result is registered and appears in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while the output is not held by m_tready; the colour
// table is a single-port-write, single-port-read synchronous memory with a registered read.
// Reset: asynchronous, active low; parser returns to the header phase.
// The colour table is not cleared; entries read are always written first.
// Top level of the TGA stream decoder; depends on tga_pkg and assert_macros.svh.
// Parser, colour table memory and output register.
`default_nettype none
`include "assert_macros.svh"
module tga_stream_decoder_top #(
    parameter int MAP_ENTRIES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // data_byte[7:0]
    input  wire logic        s_tuser,  // file_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // error_code[1:0], image_width[17:2], image_height[33:18], red[41:34],
    // green[49:42], blue[57:50], alpha[65:58], run_count[73:66], zero[79:74]
    output logic [79:0]      m_tdata,
    output logic [1:0]       m_tuser,  // result_kind[1:0]
    output logic             m_tlast   // image_last
);
    import tga_pkg::*;

    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    phase_t      phase_reg, phase_next;
    logic [15:0] fbc_reg, fbc_next;
    logic [7:0]  hdr_reg [17];
    logic [7:0]  hdr_next [17];
    logic [15:0] mec_reg, mec_next;
    logic [31:0] pb_reg, pb_next;
    logic [2:0]  bip_reg, bip_next;
    logic [7:0]  pr_reg, pr_next;
    logic        run_reg, run_next;
    logic [31:0] pl_reg, pl_next;

    logic        ov_reg, use_mem_reg;
    logic [1:0]  kind_reg, code_reg;
    logic [15:0] w_reg, h_reg;
    logic [31:0] rgba_reg, rdata_reg;
    logic [7:0]  cnt_reg;
    logic        last_reg;

    logic [31:0] mem [MAP_ENTRIES];

    logic        acc, fs;
    phase_t      ph;
    logic [15:0] fbc_e, mec_e;
    logic [31:0] pb_e, pl_e;
    logic [2:0]  bip_e;
    logic [7:0]  pr_e;
    logic        run_e;
    logic [7:0]  hb [17];
    logic [7:0]  b;

    logic [15:0] map_len, width_v, height_v;
    logic [5:0]  eb;
    logic [2:0]  eb4, npix;
    logic        is_rle, map_ok, depth_ok, type_ok;
    logic [1:0]  err;
    logic [31:0] area;
    logic [16:0] map_cnt, me17, idx17;

    // decision signals used by the phase and datapath blocks
    logic        hdr_done, to_map, map_done, map_end, pix_emit, pix_last;
    logic        pix_mapped, pix_pkt;
    logic [31:0] pb_acc, pl_after;
    logic [7:0]  count;
    logic [2:0]  bip_inc;
    logic [15:0] fbc_inc;

    logic        emit, we, re;
    logic [1:0]  e_kind, e_code;
    logic [31:0] e_rgba;
    logic        e_use_mem;

    assign acc = s_tvalid && s_tready;
    assign s_tready = !ov_reg || m_tready;
    assign fs = s_tuser;
    assign b = s_tdata;

    // file_start clears the parse state before this byte is taken
    assign ph    = fs ? PH_HEADER : phase_reg;
    assign fbc_e = fs ? 16'd0 : fbc_reg;
    assign mec_e = fs ? 16'd0 : mec_reg;
    assign pb_e  = fs ? 32'd0 : pb_reg;
    assign pl_e  = fs ? 32'd0 : pl_reg;
    assign bip_e = fs ? 3'd0 : bip_reg;
    assign pr_e  = fs ? 8'd0 : pr_reg;
    assign run_e = fs ? 1'b0 : run_reg;
    always_comb
    begin
        for (int i = 0; i < 17; i++)
            hb[i] = fs ? 8'd0 : hdr_reg[i];
    end

    assign map_len  = {hb[6], hb[5]};
    assign width_v  = {hb[13], hb[12]};
    assign height_v = {hb[15], hb[14]};
    assign eb       = 6'((9'(hb[7]) + 9'd7) >> 3);
    assign eb4      = (eb > 6'd4) ? 3'd4 : eb[2:0];
    assign npix     = hb[16][5:3];
    assign is_rle   = (hb[2] == TYPE_RLE_TRUE) || (hb[2] == TYPE_RLE_GREY);
    assign map_ok   = (hb[1] == 8'd1) && (map_len != 16'd0) && (eb != 6'd0);
    assign type_ok  = (hb[2] == TYPE_MAPPED) || (hb[2] == TYPE_TRUE) || (hb[2] == TYPE_GREY)
                      || is_rle;
    assign depth_ok = (hb[16] == 8'd8) || (hb[16] == 8'd16) || (hb[16] == 8'd24)
                      || (hb[16] == 8'd32);
    assign err = !type_ok ? ERR_TYPE : (!depth_ok ? ERR_DEPTH
                 : ((hb[1] > 8'd1) ? ERR_MAP : ERR_NONE));
    assign area = 32'(width_v) * 32'(height_v);

    assign me17    = 17'(MAP_ENTRIES);
    assign map_cnt = ((hb[1] != 8'd1) || (eb == 6'd0)) ? 17'd0
                     : (({1'b0, map_len} < me17) ? {1'b0, map_len} : me17);
    assign idx17   = ({9'd0, b} < map_cnt) ? {9'd0, b} : (map_cnt - 17'd1);

    assign fbc_inc  = fbc_e + 16'd1;
    assign bip_inc  = bip_e + 3'd1;
    assign hdr_done = (ph == PH_HEADER) && (fbc_e == 16'(HDR_LAST));
    assign to_map   = (hdr_done && (err == ERR_NONE) && (hb[0] == 8'd0))
                      || ((ph == PH_IDSKIP) && (fbc_inc >= 16'(hb[0])));
    assign map_done = (ph == PH_MAP) && (fbc_inc >= 16'(eb));
    assign map_end  = map_done && ((mec_e + 16'd1) >= map_len);

    assign pix_mapped = (ph == PH_PIXELS) && (hb[2] == TYPE_MAPPED);
    assign pix_pkt    = (ph == PH_PIXELS) && !pix_mapped && is_rle && (pr_e == 8'd0);
    assign pb_acc     = (bip_e < 3'd4) ? (pb_e | (32'(b) << {bip_e[1:0], 3'b000})) : pb_e;
    assign pix_emit   = pix_mapped
                        || ((ph == PH_PIXELS) && !pix_pkt && (bip_inc >= npix));
    assign count      = (!pix_mapped && is_rle && run_e)
                        ? ((32'(pr_e) > pl_e) ? pl_e[7:0] : pr_e) : 8'd1;
    assign pl_after   = pl_e - 32'(count);
    assign pix_last   = pix_emit && (pl_after == 32'd0);

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            phase_next = ph;
            case (ph)
                PH_HEADER:
                begin
                    if (hdr_done)
                    begin
                        if (err != ERR_NONE)
                            phase_next = PH_IDLE;
                        else if (hb[0] != 8'd0)
                            phase_next = PH_IDSKIP;
                    end
                end
                PH_IDSKIP, PH_MAP, PH_PIXELS:
                begin
                    if (pix_last)
                        phase_next = PH_IDLE;
                end
                default: phase_next = ph;
            endcase
            if (to_map)
            begin
                if (map_ok)
                    phase_next = PH_MAP;
                else
                    phase_next = ((hdr_done ? area : pl_e) == 32'd0) ? PH_IDLE : PH_PIXELS;
            end
            if (map_end)
                phase_next = (pl_e == 32'd0) ? PH_IDLE : PH_PIXELS;
        end
    end

    // datapath and result forming
    always_comb
    begin
        fbc_next = fbc_reg;
        mec_next = mec_reg;
        pb_next  = pb_reg;
        bip_next = bip_reg;
        pr_next  = pr_reg;
        run_next = run_reg;
        pl_next  = pl_reg;
        for (int i = 0; i < 17; i++)
            hdr_next[i] = hdr_reg[i];
        emit = 1'b0;
        e_kind = KIND_HEADER;
        e_code = ERR_NONE;
        e_rgba = 32'd0;
        e_use_mem = 1'b0;
        we = 1'b0;
        re = 1'b0;
        if (acc)
        begin
            fbc_next = fbc_e;
            mec_next = mec_e;
            pb_next  = pb_e;
            bip_next = bip_e;
            pr_next  = pr_e;
            run_next = run_e;
            pl_next  = pl_e;
            for (int i = 0; i < 17; i++)
                hdr_next[i] = hb[i];
            case (ph)
                PH_HEADER:
                begin
                    if (!hdr_done)
                    begin
                        hdr_next[fbc_e[4:0]] = b;
                        fbc_next = fbc_inc;
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (err != ERR_NONE)
                        begin
                            e_kind = KIND_ERROR;
                            e_code = err;
                        end
                        else
                        begin
                            pl_next = area;
                            fbc_next = 16'd0;
                        end
                    end
                end
                PH_IDSKIP: fbc_next = fbc_inc;
                PH_MAP:
                begin
                    fbc_next = fbc_inc;
                    if (fbc_e < 16'd4)
                        pb_next = pb_e | (32'(b) << {fbc_e[1:0], 3'b000});
                    if (map_done)
                    begin
                        we = 32'(mec_e) < MAP_ENTRIES;
                        pb_next = 32'd0;
                        fbc_next = 16'd0;
                        mec_next = mec_e + 16'd1;
                    end
                end
                PH_PIXELS:
                begin
                    if (pix_mapped)
                    begin
                        emit = 1'b1;
                        e_use_mem = (map_cnt != 17'd0);
                        re = e_use_mem;
                    end
                    else if (pix_pkt)
                    begin
                        run_next = b[7];
                        pr_next = {1'b0, b[6:0]} + 8'd1;
                    end
                    else
                    begin
                        pb_next = pb_acc;
                        bip_next = bip_inc;
                        if (pix_emit)
                        begin
                            emit = 1'b1;
                            e_rgba = unpack(pb_acc, npix);
                            pb_next = 32'd0;
                            bip_next = 3'd0;
                            if (is_rle)
                                pr_next = run_e ? 8'd0 : (pr_e - 8'd1);
                        end
                    end
                    if (pix_emit)
                    begin
                        e_kind = KIND_PIXEL;
                        pl_next = pl_after;
                    end
                end
                default: ;
            endcase
            if (to_map)
            begin
                fbc_next = 16'd0;
                mec_next = 16'd0;
                pb_next = 32'd0;
            end
            if (to_map || map_end)
            begin
                bip_next = 3'd0;
                pr_next = 8'd0;
                run_next = 1'b0;
                if (to_map && !map_ok)
                    pb_next = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fbc_reg <= 16'd0;
            mec_reg <= 16'd0;
            pb_reg <= 32'd0;
            bip_reg <= 3'd0;
            pr_reg <= 8'd0;
            run_reg <= 1'b0;
            pl_reg <= 32'd0;
            for (int i = 0; i < 17; i++)
                hdr_reg[i] <= 8'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fbc_reg <= fbc_next;
            mec_reg <= mec_next;
            pb_reg <= pb_next;
            bip_reg <= bip_next;
            pr_reg <= pr_next;
            run_reg <= run_next;
            pl_reg <= pl_next;
            for (int i = 0; i < 17; i++)
                hdr_reg[i] <= hdr_next[i];
            if (acc)
                ov_reg <= emit;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    // result payload, loaded with each emitted beat
    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            kind_reg <= e_kind;
            code_reg <= e_code;
            w_reg <= (e_kind == KIND_HEADER) ? width_v : 16'd0;
            h_reg <= (e_kind == KIND_HEADER) ? height_v : 16'd0;
            rgba_reg <= e_rgba;
            use_mem_reg <= e_use_mem;
            cnt_reg <= (e_kind == KIND_PIXEL) ? count : 8'd0;
            last_reg <= (e_kind == KIND_PIXEL) && pix_last;
        end
    end

    // colour table
    always_ff @(posedge clk)
    begin
        if (we)
            mem[mec_e[AW-1:0]] <= unpack(pb_next == 32'd0 ? (fbc_e < 16'd4
                ? (pb_e | (32'(b) << {fbc_e[1:0], 3'b000})) : pb_e) : pb_e, eb4);
        if (re)
            rdata_reg <= mem[idx17[AW-1:0]];
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    always_comb
    begin
        logic [31:0] px;
        px = use_mem_reg ? rdata_reg : rgba_reg;
        m_tdata = {6'd0, cnt_reg, px[31:24], px[23:16], px[15:8], px[7:0],
                   h_reg, w_reg, code_reg};
    end

    `ASSERT_WHEN(a_run_nonzero, clk, rst_n, m_tvalid && (m_tuser == KIND_PIXEL),
        m_tdata[73:66] != 8'd0, "pixel beat with zero run count")
    `ASSERT_WHEN(a_last_pixel, clk, rst_n, m_tvalid && m_tlast,
        m_tuser == KIND_PIXEL, "image_last on a non-pixel beat")
    `ASSERT_CLK(a_idle_holds, clk, rst_n,
        (acc && (phase_reg == PH_IDLE) && !s_tuser) |=> (phase_reg == PH_IDLE),
        "parser left idle without file_start")
    `ASSERT_CLK(a_no_emit_idle, clk, rst_n,
        (acc && (phase_reg == PH_IDLE) && !s_tuser) |=> !m_tvalid || $stable(m_tdata),
        "result emitted while idle")
endmodule
`default_nettype wire
